>>> rtl/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg: shared types and constants of the polyphonic voice synthesiser
// Item structs, operation and status codes, the controller command and status
// groups, and the fixed-point constants of the oscillators and envelopes.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int unsigned VOICES          = 16;
  localparam int unsigned PHASE_BITS      = 24;
  localparam int unsigned SINE_TABLE_BITS = 10;

  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CNT_W  = $clog2(VOICES + 1);
  localparam int unsigned QB     = SINE_TABLE_BITS - 2;

  // Phase step and phase alignment to the Q0.24 step and the Q0.30 turn.
  localparam int unsigned STEP_UP = (PHASE_BITS >= 24) ? (PHASE_BITS - 24) : 0;
  localparam int unsigned STEP_DN = (PHASE_BITS >= 24) ? 0 : (24 - PHASE_BITS);
  localparam int unsigned N30_UP  = (PHASE_BITS >= 30) ? 0 : (30 - PHASE_BITS);
  localparam int unsigned N30_DN  = (PHASE_BITS >= 30) ? (PHASE_BITS - 30) : 0;

  // Shared multiplier.
  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Mix accumulator: each voice adds less than 2^32 in magnitude.
  localparam int unsigned SUM_W = 33 + $clog2(VOICES);
  localparam int unsigned DIV_W = $clog2(SUM_W);

  localparam logic signed [MUL_W-1:0] ONE30        = 34'sd1073741824;
  localparam logic signed [MUL_W-1:0] ONE28        = 34'sd268435456;
  localparam logic signed [MUL_W-1:0] INT32_MAX34  = 34'sd2147483647;
  localparam logic signed [MUL_W-1:0] INT32_MIN34  = -34'sd2147483648;
  localparam logic signed [31:0]      SLOPE_INIT   = 32'sd805306368;
  localparam logic signed [MUL_W-1:0] DECAY_RATE   = 34'sd2684355;
  localparam logic signed [MUL_W-1:0] FOUR_OVER_PI = 34'sd1367130551;
  localparam logic signed [MUL_W-1:0] POLY_P0      = 34'sd172272;

  localparam logic signed [MUL_W-1:0] POLY_C [4] = '{
    -34'sd5026995, 34'sd85569306, -34'sd693598667, 34'sd1686629713
  };

  // Odd harmonics of the square: multiple, reciprocal and its shift.
  localparam logic [2:0] HARM_MULT [4] = '{3'd1, 3'd3, 3'd5, 3'd7};
  localparam logic signed [MUL_W-1:0] HARM_RECIP [4] = '{
    34'sd0, 34'sd1431655766, 34'sd6871947674, 34'sd4908534053
  };
  localparam logic [5:0] HARM_SHIFT [4] = '{6'd0, 6'd32, 6'd35, 6'd35};

  localparam logic [15:0] GAIN_RESET   = 16'd32768;
  localparam logic [31:0] PERIOD_RESET = 32'd97392;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_WAVE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_e;

  typedef enum logic [2:0] {
    ST_SAMPLE   = 3'd0,
    ST_ASSIGNED = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NOMATCH  = 3'd4,
    ST_WAVESET  = 3'd5
  } status_e;

  typedef enum logic {
    CFG_GAIN   = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key_code;
    logic [23:0] phase_step;
    logic [1:0]  wave_choice;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [2:0]         status;
    logic [5:0]         voice_index;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRESS,
    OP_RELEASE,
    OP_WAVE,
    OP_TICK_INIT,
    OP_SKIP,
    OP_ENV_MUL1,
    OP_ENV_LVL,
    OP_ENV_MUL2,
    OP_ENV_WB,
    OP_WAVE_SEL,
    OP_SIN_U,
    OP_SIN_SQ,
    OP_SIN_U2,
    OP_POLY_MUL,
    OP_POLY_ADD,
    OP_SIN_MULU,
    OP_SIN_FIN,
    OP_HARM_DIV,
    OP_HARM_ACC,
    OP_SQ_MUL,
    OP_SQ_FIN,
    OP_SIN_W,
    OP_MIX_MUL,
    OP_MIX_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN_MUL,
    OP_OUT_SAMPLE
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_VOICE,
    S_ENV_MUL1,
    S_ENV_LVL,
    S_ENV_MUL2,
    S_ENV_WB,
    S_WSEL,
    S_SIN_U,
    S_SIN_SQ,
    S_SIN_U2,
    S_POLY_MUL,
    S_POLY_ADD,
    S_SIN_MULU,
    S_SIN_FIN,
    S_HARM_DIV,
    S_HARM_ACC,
    S_SQ_MUL,
    S_SQ_FIN,
    S_SIN_W,
    S_MIX_MUL,
    S_MIX_ACC,
    S_DIV_INIT,
    S_DIV_STEP,
    S_GAIN_MUL,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [VIDX_W-1:0] voice;
    logic [1:0]        harm;
    logic [1:0]        coef;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic       playing;
    logic       active_zero;
    logic       out_free;
  } stat_t;

endpackage

>>> rtl/pvs_ctrl.sv
// ----------------------------------------------------------------------------
// pvs_ctrl: sequencer of the voice synthesiser
// Walks the voices on a tick, one datapath operation a cycle unless stalled.
// ----------------------------------------------------------------------------
module pvs_ctrl import pvs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [VIDX_W-1:0] voice_q, voice_d;
  logic [1:0]        harm_q, harm_d;
  logic [1:0]        coef_q, coef_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic              last_voice;
  logic              sq_mode;

  assign last_voice = (voice_q == VIDX_W'(VOICES - 1));
  assign sq_mode    = (stat_i.mode == WAVE_SQUARE);

  always_comb begin
    state_d = state_q;
    voice_d = voice_q;
    harm_d  = harm_q;
    coef_d  = coef_q;
    div_d   = div_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat_i.kind == KIND_TICK) begin
          state_d = S_VOICE;
          voice_d = '0;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_VOICE: begin
        if (stat_i.playing) begin
          state_d = S_ENV_MUL1;
        end else if (last_voice) begin
          state_d = S_DIV_INIT;
        end else begin
          voice_d = voice_q + 1'b1;
        end
      end
      S_ENV_MUL1: state_d = S_ENV_LVL;
      S_ENV_LVL:  state_d = S_ENV_MUL2;
      S_ENV_MUL2: state_d = S_ENV_WB;
      S_ENV_WB:   state_d = S_WSEL;
      S_WSEL: begin
        harm_d = '0;
        if (stat_i.mode == WAVE_SINE || sq_mode) state_d = S_SIN_U;
        else state_d = S_MIX_MUL;
      end
      S_SIN_U:  state_d = S_SIN_SQ;
      S_SIN_SQ: state_d = S_SIN_U2;
      S_SIN_U2: begin
        state_d = S_POLY_MUL;
        coef_d  = '0;
      end
      S_POLY_MUL: state_d = S_POLY_ADD;
      S_POLY_ADD: begin
        if (coef_q == 2'd3) begin
          state_d = S_SIN_MULU;
        end else begin
          coef_d  = coef_q + 1'b1;
          state_d = S_POLY_MUL;
        end
      end
      S_SIN_MULU: state_d = S_SIN_FIN;
      S_SIN_FIN: begin
        if (!sq_mode) state_d = S_SIN_W;
        else if (harm_q == 2'd0) state_d = S_HARM_ACC;
        else state_d = S_HARM_DIV;
      end
      S_HARM_DIV: state_d = S_HARM_ACC;
      S_HARM_ACC: begin
        if (harm_q == 2'd3) begin
          state_d = S_SQ_MUL;
        end else begin
          harm_d  = harm_q + 1'b1;
          state_d = S_SIN_U;
        end
      end
      S_SQ_MUL:  state_d = S_SQ_FIN;
      S_SQ_FIN:  state_d = S_MIX_MUL;
      S_SIN_W:   state_d = S_MIX_MUL;
      S_MIX_MUL: state_d = S_MIX_ACC;
      S_MIX_ACC: begin
        if (last_voice) begin
          state_d = S_DIV_INIT;
        end else begin
          voice_d = voice_q + 1'b1;
          state_d = S_VOICE;
        end
      end
      S_DIV_INIT: begin
        div_d = '0;
        if (stat_i.active_zero) state_d = S_OUT;
        else state_d = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (div_q == DIV_W'(SUM_W - 1)) state_d = S_GAIN_MUL;
        else div_d = div_q + 1'b1;
      end
      S_GAIN_MUL: state_d = S_OUT;
      S_OUT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.voice = voice_q;
    cmd_o.harm  = harm_q;
    cmd_o.coef  = coef_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DISPATCH: begin
        if (stat_i.kind == KIND_TICK) cmd_o.op = OP_TICK_INIT;
        else if (stat_i.out_free) begin
          unique case (stat_i.kind)
            KIND_PRESS:   cmd_o.op = OP_PRESS;
            KIND_RELEASE: cmd_o.op = OP_RELEASE;
            default:      cmd_o.op = OP_WAVE;
          endcase
        end
      end
      S_VOICE: begin
        if (!stat_i.playing) cmd_o.op = OP_SKIP;
      end
      S_ENV_MUL1: cmd_o.op = OP_ENV_MUL1;
      S_ENV_LVL:  cmd_o.op = OP_ENV_LVL;
      S_ENV_MUL2: cmd_o.op = OP_ENV_MUL2;
      S_ENV_WB:   cmd_o.op = OP_ENV_WB;
      S_WSEL:     cmd_o.op = OP_WAVE_SEL;
      S_SIN_U:    cmd_o.op = OP_SIN_U;
      S_SIN_SQ:   cmd_o.op = OP_SIN_SQ;
      S_SIN_U2:   cmd_o.op = OP_SIN_U2;
      S_POLY_MUL: cmd_o.op = OP_POLY_MUL;
      S_POLY_ADD: cmd_o.op = OP_POLY_ADD;
      S_SIN_MULU: cmd_o.op = OP_SIN_MULU;
      S_SIN_FIN:  cmd_o.op = OP_SIN_FIN;
      S_HARM_DIV: cmd_o.op = OP_HARM_DIV;
      S_HARM_ACC: cmd_o.op = OP_HARM_ACC;
      S_SQ_MUL:   cmd_o.op = OP_SQ_MUL;
      S_SQ_FIN:   cmd_o.op = OP_SQ_FIN;
      S_SIN_W:    cmd_o.op = OP_SIN_W;
      S_MIX_MUL:  cmd_o.op = OP_MIX_MUL;
      S_MIX_ACC:  cmd_o.op = OP_MIX_ACC;
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV_STEP: cmd_o.op = OP_DIV_STEP;
      S_GAIN_MUL: cmd_o.op = OP_GAIN_MUL;
      S_OUT: begin
        if (stat_i.out_free) cmd_o.op = OP_OUT_SAMPLE;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      voice_q <= '0;
      harm_q  <= '0;
      coef_q  <= '0;
      div_q   <= '0;
    end else begin
      state_q <= state_d;
      voice_q <= voice_d;
      harm_q  <= harm_d;
      coef_q  <= coef_d;
      div_q   <= div_d;
    end
  end

endmodule

>>> rtl/pvs_dp.sv
// ----------------------------------------------------------------------------
// pvs_dp: datapath of the voice synthesiser
// Voice state, configuration, one shared 34 by 34 multiplier, the mix
// accumulator, a bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module pvs_dp import pvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // Voice pool.
  logic [PHASE_BITS-1:0] phase_q [VOICES];
  logic signed [31:0]    level_q [VOICES];
  logic signed [31:0]    slope_q [VOICES];
  logic [23:0]           step_q  [VOICES];
  logic [VOICES-1:0]     playing_q, owned_q;
  logic [7:0]            owner_q [VOICES];
  logic [1:0]            mode_q;
  logic [15:0]           gain_q;
  logic [31:0]           period_q;
  in_item_t              item_q;
  out_item_t             out_q;
  logic                  out_valid_q;
  logic                  out_load;

  // Scratch registers.
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  lvl_q, p_q, acc_q, w_q;
  logic                     up_q, neg_q, sneg_q;
  logic [30:0]              u_q, u2_q, mag_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]         active_q;
  logic [SUM_W-1:0]         quo_q;
  logic [CNT_W:0]           rem_q;

  logic [VIDX_W-1:0] v;
  logic [1:0]        h;
  logic [63:0]       ph64;
  logic [29:0]       n30;
  logic [SINE_TABLE_BITS-1:0] idx, hidx;
  logic [QB-1:0]     low;
  logic [30:0]       u_raw;
  logic signed [MUL_W-1:0] saw, tri_abs, diff, sl_sum, shr30, sq_term;
  logic signed [MUL_W-1:0] quo_s, lvl_new;
  logic [PHASE_BITS-1:0]   inc;
  logic [CNT_W:0]          trial;
  logic [VIDX_W-1:0] free_idx, rel_idx;
  logic              free_ok, rel_ok;
  logic signed [PROD_W-1:0] s_full;
  logic signed [23:0]       s_sat;
  logic [VOICES-1:0]        key_hit;

  assign v = cmd_i.voice;
  assign h = cmd_i.harm;

  always_comb begin
    ph64    = 64'(phase_q[v]);
    n30     = 30'((ph64 << N30_UP) >> N30_DN);
    idx     = n30[29 -: SINE_TABLE_BITS];
    hidx    = SINE_TABLE_BITS'(32'(idx) * 32'(HARM_MULT[h]));
    low     = hidx[QB-1:0];
    u_raw   = 31'(low) << (30 - QB);
    saw     = $signed({3'b000, n30, 1'b0}) - ONE30;
    tri_abs = (saw < 0) ? -saw : saw;
    inc     = PHASE_BITS'((64'(step_q[v]) << STEP_UP) >> STEP_DN);
    diff    = ONE28 - lvl_q;
    if (diff > INT32_MAX34) diff = INT32_MAX34;
    shr30   = MUL_W'(prod_q >>> 30);
    sq_term = (h == 2'd0) ? $signed({3'b000, mag_q})
                          : MUL_W'(prod_q >> HARM_SHIFT[h]);
    if (neg_q) sq_term = -sq_term;
    sl_sum  = up_q ? (MUL_W'(slope_q[v]) + MUL_W'(prod_q >>> 32))
                   : (MUL_W'(slope_q[v]) - MUL_W'(prod_q >>> 32));
    lvl_new = MUL_W'(level_q[v]) + MUL_W'(prod_q >>> 32);
    quo_s   = sneg_q ? -MUL_W'(quo_q) : MUL_W'(quo_q);
    trial   = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]} - (CNT_W+1)'(active_q);
    s_full  = prod_q >>> 24;
    if (s_full > 68'sd8388607) s_sat = 24'sh7FFFFF;
    else if (s_full < -68'sd8388608) s_sat = -24'sh800000;
    else s_sat = 24'(s_full);
  end

  // First free voice and first voice owned by the key.
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    rel_ok   = 1'b0;
    rel_idx  = '0;
    for (int i = 0; i < VOICES; i++) begin
      key_hit[i] = owned_q[i] && (owner_q[i] == item_q.key_code);
    end
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!playing_q[i]) begin
        free_ok  = 1'b1;
        free_idx = VIDX_W'(i);
      end
      if (key_hit[i]) begin
        rel_ok  = 1'b1;
        rel_idx = VIDX_W'(i);
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_ENV_MUL1: begin
        mul_a = MUL_W'(slope_q[v]);
        mul_b = $signed({2'b00, period_q});
      end
      OP_ENV_MUL2: begin
        mul_a = (lvl_q < ONE28) ? diff : DECAY_RATE;
        mul_b = $signed({2'b00, period_q});
      end
      OP_SIN_SQ: begin
        mul_a = $signed({3'b000, u_q});
        mul_b = $signed({3'b000, u_q});
      end
      OP_POLY_MUL: begin
        mul_a = p_q;
        mul_b = $signed({3'b000, u2_q});
      end
      OP_SIN_MULU: begin
        mul_a = p_q;
        mul_b = $signed({3'b000, u_q});
      end
      OP_HARM_DIV: begin
        mul_a = $signed({3'b000, mag_q});
        mul_b = HARM_RECIP[h];
      end
      OP_SQ_MUL: begin
        mul_a = acc_q;
        mul_b = FOUR_OVER_PI;
      end
      OP_MIX_MUL: begin
        mul_a = w_q;
        mul_b = MUL_W'(level_q[v]);
      end
      OP_GAIN_MUL: begin
        mul_a = quo_s;
        mul_b = $signed({18'd0, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // A new result is loaded only when the output register is free.
  assign out_load = (cmd_i.op == OP_PRESS) || (cmd_i.op == OP_RELEASE) ||
                    (cmd_i.op == OP_WAVE) || (cmd_i.op == OP_OUT_SAMPLE);

  // Voice state, configuration and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_q[i] <= '0;
        level_q[i] <= '0;
        slope_q[i] <= SLOPE_INIT;
        step_q[i]  <= '0;
        owner_q[i] <= '0;
      end
      playing_q   <= '0;
      owned_q     <= '0;
      mode_q      <= WAVE_SQUARE;
      gain_q      <= GAIN_RESET;
      period_q    <= PERIOD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN:   gain_q   <= cfg_data_i[15:0];
          CFG_PERIOD: period_q <= cfg_data_i;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        OP_PRESS: begin
          if (free_ok) begin
            owned_q <= (owned_q & ~key_hit) | (VOICES'(1) << free_idx);
            playing_q[free_idx] <= 1'b1;
            step_q[free_idx]    <= item_q.phase_step;
            owner_q[free_idx]   <= item_q.key_code;
          end
        end
        OP_RELEASE: begin
          if (rel_ok) begin
            playing_q[rel_idx] <= 1'b0;
            owned_q[rel_idx]   <= 1'b0;
          end
        end
        OP_WAVE: mode_q <= item_q.wave_choice;
        OP_SKIP, OP_MIX_ACC: phase_q[v] <= phase_q[v] + inc;
        OP_ENV_WB: begin
          if (sl_sum > INT32_MAX34) slope_q[v] <= 32'sh7FFFFFFF;
          else if (sl_sum < INT32_MIN34) slope_q[v] <= -32'sh80000000;
          else slope_q[v] <= 32'(sl_sum);
          if (lvl_q < 0) level_q[v] <= '0;
          else if (lvl_q > ONE28) level_q[v] <= 32'(ONE28);
          else level_q[v] <= 32'(lvl_q);
        end
        default: ;
      endcase
    end
  end

  // Scratch and payload registers. The product is held while the sequencer
  // waits, so that a stalled output keeps the scaled mix.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) prod_q <= prod_d;
    unique case (cmd_i.op)
      OP_LOAD: item_q <= in_data_i;
      OP_PRESS: begin
        out_q.sample      <= '0;
        out_q.status      <= free_ok ? ST_ASSIGNED : ST_FULL;
        out_q.voice_index <= free_ok ? 6'(free_idx) : 6'd0;
      end
      OP_RELEASE: begin
        out_q.sample      <= '0;
        out_q.status      <= rel_ok ? ST_RELEASED : ST_NOMATCH;
        out_q.voice_index <= rel_ok ? 6'(rel_idx) : 6'd0;
      end
      OP_WAVE: begin
        out_q.sample      <= '0;
        out_q.status      <= ST_WAVESET;
        out_q.voice_index <= '0;
      end
      OP_TICK_INIT: begin
        sum_q    <= '0;
        active_q <= '0;
      end
      OP_ENV_LVL: lvl_q <= lvl_new;
      OP_ENV_MUL2: up_q <= (lvl_q < ONE28);
      OP_WAVE_SEL: begin
        acc_q <= '0;
        if (mode_q == WAVE_SAW) w_q <= saw;
        else w_q <= (tri_abs <<< 1) - ONE30;
      end
      OP_SIN_U: begin
        u_q   <= hidx[QB] ? (31'(ONE30) - u_raw) : u_raw;
        neg_q <= hidx[SINE_TABLE_BITS-1];
      end
      OP_SIN_U2: begin
        u2_q <= 31'(prod_q >> 30);
        p_q  <= POLY_P0;
      end
      OP_POLY_ADD: p_q <= POLY_C[cmd_i.coef] + shr30;
      OP_SIN_FIN: begin
        if (shr30 < 0) mag_q <= '0;
        else if (shr30 > ONE30) mag_q <= 31'(ONE30);
        else mag_q <= 31'(shr30);
      end
      OP_HARM_ACC: acc_q <= acc_q + sq_term;
      OP_SQ_FIN: w_q <= shr30;
      OP_SIN_W: w_q <= neg_q ? -$signed({3'b000, mag_q}) : $signed({3'b000, mag_q});
      OP_MIX_ACC: begin
        sum_q    <= sum_q + SUM_W'(prod_q >>> 28);
        active_q <= active_q + 1'b1;
      end
      OP_DIV_INIT: begin
        sneg_q <= sum_q[SUM_W-1];
        quo_q  <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        if (!trial[CNT_W]) begin
          rem_q <= trial;
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
      end
      OP_OUT_SAMPLE: begin
        out_q.sample      <= (active_q == '0) ? 24'sd0 : s_sat;
        out_q.status      <= ST_SAMPLE;
        out_q.voice_index <= '0;
      end
      default: ;
    endcase
  end

  assign stat_o.kind        = item_q.kind;
  assign stat_o.mode        = mode_q;
  assign stat_o.playing     = playing_q[v];
  assign stat_o.active_zero = (active_q == '0);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/polyphonic_voice_synth_top.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_synth_top: polyphonic oscillator voice mixer
// Sixteen voices driven by key press, key release, waveform and tick requests.
// ----------------------------------------------------------------------------
// One request is handled at a time, and each gives exactly one result. Press,
// release and waveform requests are accepted and then dispatched once the
// output register is free. A tick walks the voices in turn through the single
// shared multiplier: a silent voice is skipped, and a playing voice has a test
// step, the envelope steps, a waveform select step (all that sawtooth and
// triangle need), the sine polynomial for sine or once per harmonic for the
// four-harmonic square, and the mix multiply and accumulate. The divider is
// then prepared, a bit-serial divider averages over the playing voices, and
// the gain is applied and the result loaded. A tick with no voice playing
// skips the division and the gain.
// A finished result waits in the output register while the next request is
// accepted; a result is only dispatched once that register is free.
// Configuration writes take effect at once and should be made only while the
// block is idle.
// ----------------------------------------------------------------------------
module polyphonic_voice_synth_top import pvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // The controller sequences the work; the datapath holds all voice state.
  cmd_t  cmd;
  stat_t stat;

  pvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pvs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/pvs_chk.sv
// ----------------------------------------------------------------------------
// pvs_chk: port checker of the voice synthesiser
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module pvs_chk import pvs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o,
  input logic        cfg_we_i,
  input logic        cfg_idx_i,
  input logic [31:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while one is in progress");

  a_sample_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_SAMPLE |-> out_data_o.sample == '0)
    else $error("non-zero sample on a non-tick result");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_SAMPLE || out_data_o.status == ST_FULL ||
                    out_data_o.status == ST_NOMATCH || out_data_o.status == ST_WAVESET)
    |-> out_data_o.voice_index == '0)
    else $error("voice index set on a result without a voice");

endmodule

bind polyphonic_voice_synth_top pvs_chk u_pvs_chk (.*);

>>> tb/polyphonic_voice_synth_top_tb.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_synth_top_tb: self-checking bench of the voice synthesiser
// A directed table of requests followed by random press, release, waveform and
// tick traffic, each result compared with an in-bench model of the voice pool.
// ----------------------------------------------------------------------------
module polyphonic_voice_synth_top_tb import pvs_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  polyphonic_voice_synth_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state of the voice pool and its registers.
  logic [15:0]        gain_m;
  logic [31:0]        period_m;
  logic [23:0]        phase_m [VOICES];
  longint             level_m [VOICES];
  longint             slope_m [VOICES];
  logic [23:0]        step_m  [VOICES];
  bit                 playing_m [VOICES];
  bit                 used_m  [VOICES];
  logic [7:0]         owner_m [VOICES];
  bit                 owned_m [VOICES];
  wave_e              mode_m;

  out_item_t pending_results [$];
  int        errors = 0;
  int        idle_cycles = 0;

  // Arithmetic shift right rounding towards minus infinity.
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sine_val(int unsigned idx);
    int unsigned quad;
    longint u, u2, p;
    quad = (idx >> QB) & 3;
    u = longint'(idx & ((1 << QB) - 1)) << (30 - QB);
    if (quad & 1) u = 64'sd1073741824 - u;
    u2 = (u * u) >>> 30;
    p = 172272;
    p = -5026995 + fshr(p * u2, 30);
    p = 85569306 + fshr(p * u2, 30);
    p = -693598667 + fshr(p * u2, 30);
    p = 1686629713 + fshr(p * u2, 30);
    p = fshr(p * u, 30);
    if (p < 0) p = 0;
    if (p > 64'sd1073741824) p = 64'sd1073741824;
    return (quad >= 2) ? -p : p;
  endfunction

  function automatic longint wave_val(logic [23:0] ph);
    longint n30, t, acc;
    int unsigned idx, tm;
    n30 = longint'(ph) << 6;
    idx = int'(n30 >> 20);
    tm = (1 << SINE_TABLE_BITS) - 1;
    case (mode_m)
      WAVE_SINE: return sine_val(idx);
      WAVE_SAW:  return 2 * n30 - 64'sd1073741824;
      WAVE_SQUARE: begin
        acc = sine_val(idx) + sine_val((3 * idx) & tm) / 3
            + sine_val((5 * idx) & tm) / 5 + sine_val((7 * idx) & tm) / 7;
        return fshr(acc * 64'sd1367130551, 30);
      end
      default: begin
        t = 2 * n30 - 64'sd1073741824;
        if (t < 0) t = -t;
        return 2 * t - 64'sd1073741824;
      end
    endcase
  endfunction

  function automatic void advance_envelope(int v);
    longint dt, lvl, sl, diff;
    dt = longint'(period_m);
    lvl = level_m[v] + fshr(slope_m[v] * dt, 32);
    sl = slope_m[v];
    if (lvl < 64'sd268435456) begin
      diff = 64'sd268435456 - lvl;
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      sl += fshr(diff * dt, 32);
    end else begin
      sl -= fshr(64'sd2684355 * dt, 32);
    end
    if (sl > 64'sd2147483647) sl = 64'sd2147483647;
    if (sl < -64'sd2147483648) sl = -64'sd2147483648;
    slope_m[v] = sl;
    if (lvl < 0) lvl = 0;
    if (lvl > 64'sd268435456) lvl = 64'sd268435456;
    level_m[v] = lvl;
  endfunction

  function automatic void reset_pool();
    gain_m = GAIN_RESET;
    period_m = PERIOD_RESET;
    mode_m = WAVE_SQUARE;
    for (int v = 0; v < VOICES; v++) begin
      phase_m[v] = '0; level_m[v] = 0; slope_m[v] = SLOPE_INIT; step_m[v] = '0;
      playing_m[v] = 0; used_m[v] = 0; owner_m[v] = '0; owned_m[v] = 0;
    end
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic out_item_t synth_result(in_item_t req);
    out_item_t r;
    longint acc, active, mix, smp;
    int found;
    r = '0;
    case (kind_e'(req.kind))
      KIND_TICK: begin
        acc = 0; active = 0;
        for (int v = 0; v < VOICES; v++) begin
          if (playing_m[v]) begin
            advance_envelope(v);
            acc += fshr(wave_val(phase_m[v]) * level_m[v], 28);
            active++;
          end
          phase_m[v] = phase_m[v] + step_m[v];
        end
        r.status = ST_SAMPLE;
        if (active > 0) begin
          mix = fshr((acc / active) * longint'(gain_m), 16);
          smp = fshr(mix, 8);
          if (smp > 8388607) smp = 8388607;
          if (smp < -8388608) smp = -8388608;
          r.sample = smp[23:0];
        end
      end
      KIND_PRESS: begin
        found = -1;
        for (int v = 0; v < VOICES; v++)
          if (!playing_m[v] && found < 0) found = v;
        if (found < 0) begin
          r.status = ST_FULL;
        end else begin
          for (int v = 0; v < VOICES; v++)
            if (owned_m[v] && owner_m[v] == req.key_code) owned_m[v] = 0;
          if (!used_m[found]) begin
            level_m[found] = 0; slope_m[found] = SLOPE_INIT;
            phase_m[found] = '0; used_m[found] = 1;
          end
          step_m[found] = req.phase_step;
          playing_m[found] = 1;
          owner_m[found] = req.key_code;
          owned_m[found] = 1;
          r.status = ST_ASSIGNED;
          r.voice_index = 6'(found);
        end
      end
      KIND_RELEASE: begin
        r.status = ST_NOMATCH;
        found = -1;
        for (int v = 0; v < VOICES; v++)
          if (found < 0 && owned_m[v] && owner_m[v] == req.key_code) found = v;
        if (found >= 0) begin
          playing_m[found] = 0; owned_m[found] = 0;
          r.status = ST_RELEASED;
          r.voice_index = 6'(found);
        end
      end
      default: begin
        mode_m = wave_e'(req.wave_choice);
        r.status = ST_WAVESET;
      end
    endcase
    return r;
  endfunction

  // Receiver: random back-pressure and the comparison with the oldest
  // expectation. Sampling happens at the edge, so the order of events within
  // a step does not matter.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: %h", out_data_o);
          errors++;
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          if (out_data_o.sample !== e.sample) begin
            $error("sample: expected %0d, got %0d", e.sample, out_data_o.sample);
            errors++;
          end
          if (out_data_o.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_data_o.status);
            errors++;
          end
          if (out_data_o.voice_index !== e.voice_index) begin
            $error("voice_index: expected %0d, got %0d", e.voice_index,
                   out_data_o.voice_index);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(1, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sends one request, after a random gap, and records its expected result.
  // Valid stays high after acceptance until the next gap or the next drain,
  // so back-to-back requests keep it asserted.
  task automatic send_request(in_item_t req);
    int gap;
    out_item_t exp_res;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = synth_result(req);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GAIN) gain_m = val[15:0];
    else period_m = val;
    @(posedge clk_i);
  endtask

  // Waits until every result is back, so that registers may be rewritten.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t make_req(kind_e k, logic [7:0] key,
                                        logic [23:0] stp, wave_e w);
    in_item_t q;
    q.kind = k; q.key_code = key; q.phase_step = stp; q.wave_choice = w;
    return q;
  endfunction

  // Directed table: request plus, where obvious, the typed result.
  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } row_t;

  // Random request, mostly well formed: presses of a small key set so that
  // releases usually match, with ticks dominating.
  function automatic in_item_t random_req();
    int pick;
    in_item_t q;
    q.kind = 2'($urandom);
    q.key_code = 8'($urandom);
    q.phase_step = 24'($urandom);
    q.wave_choice = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) q.kind = KIND_TICK;
    else if (pick < 72) q.kind = KIND_PRESS;
    else if (pick < 92) q.kind = KIND_RELEASE;
    else q.kind = KIND_WAVE;
    if ($urandom_range(0, 4) != 0) q.key_code = 8'($urandom_range(0, 23));
    if ($urandom_range(0, 3) == 0) q.phase_step = 24'($urandom_range(0, 4095) << 12);
    return q;
  endfunction

  initial begin
    row_t rows [$];
    row_t rw;
    out_item_t got;
    reset_pool();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: silent tick, a release that misses, every waveform, a
    // full pool, a key pressed twice and the extreme field values.
    rw.typed = 1; rw.res = '0;
    rw.req = make_req(KIND_TICK, 8'h00, 24'h0, WAVE_SINE); rw.res.status = ST_SAMPLE;
    rows = {rows, rw};
    rw.req = make_req(KIND_RELEASE, 8'hff, 24'h0, WAVE_SINE); rw.res.status = ST_NOMATCH;
    rows = {rows, rw};
    rw.typed = 0;
    rw.req = make_req(KIND_PRESS, 8'hff, 24'hffffff, WAVE_TRI); rows = {rows, rw};
    rw.req = make_req(KIND_PRESS, 8'h00, 24'h000000, WAVE_SINE); rows = {rows, rw};
    rw.req = make_req(KIND_PRESS, 8'hff, 24'h123457, WAVE_SINE); rows = {rows, rw};
    for (int w = 0; w < 4; w++) begin
      rw.req = make_req(KIND_WAVE, 8'h5a, 24'h0, wave_e'(w)); rows = {rows, rw};
      rw.req = make_req(KIND_TICK, 8'ha5, 24'haaaaaa, WAVE_SINE); rows = {rows, rw};
    end
    for (int k = 0; k < VOICES - 2; k++) begin
      rw.req = make_req(KIND_PRESS, 8'(k + 1), 24'(k * 24'h0f0f0f + 24'h10101), WAVE_SAW);
      rows = {rows, rw};
    end
    rw.typed = 1; rw.res = '0;
    rw.req = make_req(KIND_PRESS, 8'h80, 24'h555555, WAVE_SQUARE); rw.res.status = ST_FULL;
    rows = {rows, rw};

    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].typed) begin
        got = pending_results[$];
        if (got !== rows[i].res) begin
          $error("table row %0d: expected %h, model %h", i, rows[i].res, got);
          errors++;
        end
      end
    end
    drain();

    // Random phases at a range of register settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_GAIN, 32'hffff); write_reg(CFG_PERIOD, 32'hffffffff); end
        1: begin write_reg(CFG_GAIN, 32'h0);    write_reg(CFG_PERIOD, 32'h0); end
        2: begin write_reg(CFG_GAIN, $urandom); write_reg(CFG_PERIOD, $urandom); end
        3: begin write_reg(CFG_GAIN, 32'hffff); write_reg(CFG_PERIOD, $urandom_range(0, 1 << 24)); end
        default: begin write_reg(CFG_GAIN, GAIN_RESET); write_reg(CFG_PERIOD, PERIOD_RESET); end
      endcase
      for (int n = 0; n < 160; n++) send_request(random_req());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
